/* hw/rtl/dtoi_pkg.sv */
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and codes for the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtoi_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SYNTAX = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   // width_mode codes, anything else acts as 64 bits
   localparam logic [1:0] WIDTH_16 = 2'd0;
   localparam logic [1:0] WIDTH_32 = 2'd1;
   localparam logic [1:0] WIDTH_64 = 2'd2;

   // register indexes, taken from paddr[2]
   localparam logic REG_WIDTH_MODE  = 1'b0;
   localparam logic REG_SIGNED_MODE = 1'b1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef struct packed {
      logic [1:0] width_mode;
      logic       signed_mode;
   } cfg_type;

endpackage

/* hw/rtl/dtoi_if.sv */
// ----------------------------------------------------------------------------
// dtoi channel interfaces
// Valid/ready channels for text bytes in and conversion results out.
// ----------------------------------------------------------------------------
interface dtoi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface dtoi_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

/* hw/rtl/dtoi_csr.sv */
// ----------------------------------------------------------------------------
// dtoi_csr
// APB-style register file holding width_mode and signed_mode.
// ----------------------------------------------------------------------------
module dtoi_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dtoi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dtoi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dtoi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output dtoi_pkg::cfg_type                 cfg
);

   logic [1:0] width_mode_ff;
   logic [1:0] width_mode_in;
   logic       signed_mode_ff;
   logic       signed_mode_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      width_mode_in  = width_mode_ff;
      signed_mode_in = signed_mode_ff;
      if (wr_en) begin
         if (reg_sel == dtoi_pkg::REG_WIDTH_MODE) begin
            width_mode_in = csr_pwdata[1:0];
         end else begin
            signed_mode_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff  <= dtoi_pkg::WIDTH_32;
         signed_mode_ff <= 1'b1;
      end else begin
         width_mode_ff  <= width_mode_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   always_comb begin
      if (reg_sel == dtoi_pkg::REG_WIDTH_MODE) begin
         csr_prdata = {{(dtoi_pkg::CSR_DATA_W-2){1'b0}}, width_mode_ff};
      end else begin
         csr_prdata = {{(dtoi_pkg::CSR_DATA_W-1){1'b0}}, signed_mode_ff};
      end
   end

   assign cfg.width_mode  = width_mode_ff;
   assign cfg.signed_mode = signed_mode_ff;

endmodule

/* hw/rtl/dtoi_core.sv */
// ----------------------------------------------------------------------------
// dtoi_core
// Input byte register, parse state and result register of the converter.
// ----------------------------------------------------------------------------
module dtoi_core (
   input  logic              clock,
   input  logic              reset,
   input  dtoi_pkg::cfg_type cfg,
   dtoi_req_if.sink          req_chan,
   dtoi_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_ERROR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [1:0]  err_ff, err_in;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [63:0] out_value_ff, out_value_in;

   logic        is_nul;
   logic        is_ws;
   logic        is_digit;
   logic        proc;
   logic [3:0]  digit;
   logic [67:0] next_mag;
   logic [63:0] lim;
   logic        fits;
   logic        neg_eff;
   logic        over;

   assign is_nul   = (in_byte_ff == 8'h00);
   assign is_ws    = (in_byte_ff == 8'h20) || (in_byte_ff inside {[8'h09:8'h0D]});
   assign is_digit = in_byte_ff inside {[8'h30:8'h39]};
   assign digit    = in_byte_ff[3:0];

   // a NUL needs the result register free, other bytes never wait
   assign proc = in_valid_ff && (!is_nul || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || proc;

   always_comb begin
      case (cfg.width_mode)
         dtoi_pkg::WIDTH_16: lim = cfg.signed_mode ? 64'h8000 : 64'hFFFF;
         dtoi_pkg::WIDTH_32: lim = cfg.signed_mode ? 64'h8000_0000 : 64'hFFFF_FFFF;
         default:            lim = cfg.signed_mode ? 64'h8000_0000_0000_0000 : '1;
      endcase
   end

   // acc*10 + d as shift-add, checked against the limit in full width
   assign next_mag = {3'b000, acc_ff, 1'b0} + {1'b0, acc_ff, 3'b000} + {64'd0, digit};
   assign fits     = (next_mag <= {4'd0, lim});

   assign neg_eff = cfg.signed_mode && neg_ff;
   assign over    = (acc_ff > lim) || (cfg.signed_mode && !neg_eff && (acc_ff == lim));

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      err_in        = err_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;

      if (proc) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.text_byte;
      end

      if (proc) begin
         if (is_nul) begin
            out_valid_in = 1'b1;
            out_value_in = '0;
            case (phase_ff)
               PH_ERROR: out_status_in = err_ff;
               PH_LEAD, PH_SIGN: out_status_in = dtoi_pkg::STATUS_SYNTAX;
               default: begin
                  if (over) begin
                     out_status_in = dtoi_pkg::STATUS_RANGE;
                  end else begin
                     out_status_in = dtoi_pkg::STATUS_OK;
                     out_value_in  = neg_eff ? (64'd0 - acc_ff) : acc_ff;
                  end
               end
            endcase
            phase_in = PH_LEAD;
            acc_in   = '0;
            neg_in   = 1'b0;
            err_in   = dtoi_pkg::STATUS_OK;
         end else begin
            case (phase_ff)
               PH_LEAD, PH_SIGN, PH_DIGITS: begin
                  if (is_digit) begin
                     if (fits) begin
                        acc_in   = next_mag[63:0];
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_ERROR;
                        err_in   = dtoi_pkg::STATUS_RANGE;
                     end
                  end else if (phase_ff == PH_LEAD && is_ws) begin
                     phase_in = PH_LEAD;
                  end else if (phase_ff == PH_LEAD && in_byte_ff == 8'h2D
                               && cfg.signed_mode) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGN;
                  end else if (phase_ff == PH_LEAD && in_byte_ff == 8'h2B) begin
                     phase_in = PH_SIGN;
                  end else if (phase_ff == PH_DIGITS && is_ws) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_ERROR;
                     err_in   = dtoi_pkg::STATUS_SYNTAX;
                  end
               end
               PH_TRAIL: begin
                  if (!is_ws) begin
                     phase_in = PH_ERROR;
                     err_in   = dtoi_pkg::STATUS_SYNTAX;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         err_ff       <= dtoi_pkg::STATUS_OK;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.status = out_status_ff;
   assign rsp_chan.value  = out_value_ff;

endmodule

/* hw/rtl/decimal_text_to_integer.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Streams ASCII text bytes and returns one parsed integer per string.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one text byte per item; a zero byte ends the string.
//   rsp_chan carries one item per string: status (ok, syntax or range
//   error) and the value, sign-extended in signed mode, zero unless ok.
//   The csr_ port sets width_mode (16/32/64 bits) and signed_mode; write
//   it only while no string is in flight.
// Timing:
//   one byte is taken every cycle unless a zero byte waits for the result
//   register; each byte passes the input register and is parsed from it in
//   the next cycle, a waiting zero byte once the slot frees; the terminating
//   byte then sets the result register, which holds the result item. The
//   per-byte logic is the multiply-by-ten shift-add and its compare to the limit.
// Reset:
//   synchronous; the parser returns to the leading whitespace phase, both
//   registers go to 32-bit signed, and no result is pending.
// Stall:
//   while a result waits on rsp_chan.ready, bytes other than a zero keep
//   flowing; a second zero byte holds req_chan.ready low until the slot frees.
// ----------------------------------------------------------------------------
module decimal_text_to_integer (
   input  logic                              clock,
   input  logic                              reset,
   dtoi_req_if.sink                          req_chan,
   dtoi_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dtoi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dtoi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dtoi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   dtoi_pkg::cfg_type cfg;

   dtoi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dtoi_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

/* hw/rtl/dtoi_checker.sv */
// ----------------------------------------------------------------------------
// dtoi_checker
// Port-level checks on the result channel of the converter.
// ----------------------------------------------------------------------------
module dtoi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_value))
      else $error("stalled result item changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dtoi_pkg::STATUS_OK |-> rsp_value == 64'd0)
      else $error("error result carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == dtoi_pkg::STATUS_OK
                    || rsp_status == dtoi_pkg::STATUS_SYNTAX
                    || rsp_status == dtoi_pkg::STATUS_RANGE)
      else $error("undefined status code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind decimal_text_to_integer dtoi_checker u_dtoi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_value  (rsp_chan.value)
);
